// ===== rtl/psch_pkg.sv =====
// ----------------------------------------------------------------------------
// psch_pkg
// Shared types, codes and helpers for the plane separation test of two
// curve control polygons.
// ----------------------------------------------------------------------------
package psch_pkg;

    // Sign of a distance, held as a two-bit two's complement value.
    typedef logic [1:0] t_sign;
    localparam t_sign SGN_ZERO = 2'b00;
    localparam t_sign SGN_POS  = 2'b01;
    localparam t_sign SGN_NEG  = 2'b11;

    // Configuration register indexes.
    typedef logic [2:0] t_cfg_idx;
    localparam t_cfg_idx CFG_PLANE_X   = 3'd0;
    localparam t_cfg_idx CFG_PLANE_Y   = 3'd1;
    localparam t_cfg_idx CFG_PLANE_Z   = 3'd2;
    localparam t_cfg_idx CFG_NORMAL_X  = 3'd3;
    localparam t_cfg_idx CFG_NORMAL_Y  = 3'd4;
    localparam t_cfg_idx CFG_NORMAL_Z  = 3'd5;
    localparam t_cfg_idx CFG_TOLERANCE = 3'd6;
    localparam t_cfg_idx CFG_SIDE_SIGN = 3'd7;

    localparam int CFG_DATA_W = 64;
    localparam int TOL_W      = 63;
    localparam int SIDE_W     = 2;

    // Classification queue between front and back.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    // Per-point flags that travel with the word.
    typedef struct packed {
        logic which_curve;
        logic is_bezier_curve;
        logic is_end_coef;
        logic last_of_test;
    } t_tag;

    // One classified point as it sits in the queue.
    typedef struct packed {
        t_sign sgn;
        logic  near_tol;
        t_tag  tag;
    } t_qent;

    // Product of two signs.
    function automatic t_sign f_sign_mul(input t_sign a, input t_sign b);
        t_sign r;
        if (a == SGN_ZERO || b == SGN_ZERO) begin
            r = SGN_ZERO;
        end else if (a == b) begin
            r = SGN_POS;
        end else begin
            r = SGN_NEG;
        end
        return r;
    endfunction

    // Only the sign of the orientation register is used.
    function automatic t_sign f_side(input logic [SIDE_W-1:0] v);
        t_sign r;
        if (v[1]) begin
            r = SGN_NEG;
        end else if (v[0]) begin
            r = SGN_POS;
        end else begin
            r = SGN_ZERO;
        end
        return r;
    endfunction

endpackage

// ===== rtl/psch_front.sv =====
// ----------------------------------------------------------------------------
// psch_front
// Accepts control points, computes the exact signed plane distance over three
// stages and classifies it by sign and tolerance for the queue.
// ----------------------------------------------------------------------------
module psch_front #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [COORD_WIDTH-1:0]     i_coef_x,
    input  logic [COORD_WIDTH-1:0]     i_coef_y,
    input  logic [COORD_WIDTH-1:0]     i_coef_z,
    input  psch_pkg::t_tag             i_tag,
    input  logic [COORD_WIDTH-1:0]     i_plane_x,
    input  logic [COORD_WIDTH-1:0]     i_plane_y,
    input  logic [COORD_WIDTH-1:0]     i_plane_z,
    input  logic [COORD_WIDTH-1:0]     i_normal_x,
    input  logic [COORD_WIDTH-1:0]     i_normal_y,
    input  logic [COORD_WIDTH-1:0]     i_normal_z,
    input  logic [psch_pkg::TOL_W-1:0] i_tolerance,
    input  logic                       i_q_full,
    output logic                       o_push,
    output psch_pkg::t_qent            o_ent
);
    import psch_pkg::*;

    localparam int DFW  = COORD_WIDTH + 1;
    localparam int PW   = 2 * COORD_WIDTH + 1;
    localparam int DW   = 2 * COORD_WIDTH + 3;
    localparam int CMPW = ((DW > 64) ? DW : 64) + 1;

    logic                   en;
    logic [2:0]             r_v;
    t_tag                   r_tag [3];
    logic [DFW-1:0]         r_dx [3];
    logic signed [PW-1:0]   r_pr [3];
    logic signed [DW-1:0]   r_d;
    logic [COORD_WIDTH-1:0] plane [3];
    logic [COORD_WIDTH-1:0] coef [3];
    logic [COORD_WIDTH-1:0] normal [3];
    logic signed [CMPW-1:0] d_ext;
    logic signed [CMPW-1:0] tol_ext;

    assign plane  = '{i_plane_x, i_plane_y, i_plane_z};
    assign coef   = '{i_coef_x, i_coef_y, i_coef_z};
    assign normal = '{i_normal_x, i_normal_y, i_normal_z};

    // The whole front pipeline holds when its last stage cannot enter the queue.
    assign en      = !(r_v[2] && i_q_full);
    assign o_stall = !en;
    assign o_push  = en && r_v[2];

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    // Stage one: difference, stage two: products, stage three: sum.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tag[0] <= i_tag;
            r_tag[1] <= r_tag[0];
            r_tag[2] <= r_tag[1];
            for (int k = 0; k < 3; k++) begin
                r_dx[k] <= {plane[k][COORD_WIDTH-1], plane[k]}
                         - {coef[k][COORD_WIDTH-1], coef[k]};
                r_pr[k] <= $signed(r_dx[k]) * $signed(normal[k]);
            end
            r_d <= $signed({{2{r_pr[0][PW-1]}}, r_pr[0]})
                 + $signed({{2{r_pr[1][PW-1]}}, r_pr[1]})
                 + $signed({{2{r_pr[2][PW-1]}}, r_pr[2]});
        end
    end

    // Classification: sign of the distance and whether it lies within tolerance.
    assign d_ext   = $signed({{(CMPW-DW){r_d[DW-1]}}, r_d});
    assign tol_ext = $signed({{(CMPW-TOL_W){1'b0}}, i_tolerance});

    always_comb begin
        if (r_d == '0) begin
            o_ent.sgn = SGN_ZERO;
        end else if (r_d[DW-1]) begin
            o_ent.sgn = SGN_NEG;
        end else begin
            o_ent.sgn = SGN_POS;
        end
        o_ent.near_tol = (d_ext <= tol_ext) && (d_ext >= -tol_ext);
        o_ent.tag      = r_tag[2];
    end

endmodule

// ===== rtl/psch_queue.sv =====
// ----------------------------------------------------------------------------
// psch_queue
// Short first-in first-out queue of classified points between the front and
// the back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module psch_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  psch_pkg::t_qent i_ent,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_nonempty,
    output psch_pkg::t_qent o_head
);
    import psch_pkg::*;

    t_qent           r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_CW-1:0] r_cnt;

    assign o_full     = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_mem[r_rd];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + Q_CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - Q_CW'(1);
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_ent;
        end
    end

endmodule

// ===== rtl/psch_back.sv =====
// ----------------------------------------------------------------------------
// psch_back
// Runs the sign sequence over the classified points, decides the verdict and
// holds the single result in an output register.
// ----------------------------------------------------------------------------
module psch_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_nonempty,
    input  psch_pkg::t_qent             i_head,
    output logic                        o_pop,
    input  logic [psch_pkg::SIDE_W-1:0] i_side_sign,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_possible_intersection
);
    import psch_pkg::*;

    t_sign r_rs;
    t_sign r_fcs;
    logic  r_in2;
    logic  r_vf;
    logic  r_out_valid;
    logic  r_out_pi;
    t_sign n_rs;
    t_sign n_fcs;
    logic  n_in2;
    logic  n_vf;

    // A word is taken unless it would send a result into a stalled output register.
    assign o_pop = i_nonempty && (!i_head.tag.last_of_test || !r_out_valid || !i_stall);

    // Verdict and sign tracking for the head word.
    always_comb begin
        n_rs  = r_rs;
        n_fcs = r_fcs;
        n_in2 = r_in2;
        n_vf  = r_vf;
        if (!r_vf) begin
            if (i_head.tag.which_curve && !r_in2) begin
                n_fcs = f_sign_mul(f_side(i_side_sign), r_rs);
                n_rs  = SGN_ZERO;
                n_in2 = 1'b1;
            end
            if (i_head.near_tol && !i_head.tag.is_bezier_curve && !i_head.tag.is_end_coef) begin
                n_vf = 1'b1;
            end else if (f_sign_mul(n_rs, i_head.sgn) == SGN_NEG) begin
                n_vf = 1'b1;
            end else if (n_in2 && f_sign_mul(n_fcs, n_rs) == SGN_POS) begin
                n_vf = 1'b1;
            end else begin
                n_rs = i_head.sgn;
            end
        end
    end

    // Test state; cleared at the end of every test.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rs  <= SGN_ZERO;
            r_fcs <= SGN_ZERO;
            r_in2 <= 1'b0;
            r_vf  <= 1'b0;
        end else if (o_pop) begin
            if (i_head.tag.last_of_test) begin
                r_rs  <= SGN_ZERO;
                r_fcs <= SGN_ZERO;
                r_in2 <= 1'b0;
                r_vf  <= 1'b0;
            end else begin
                r_rs  <= n_rs;
                r_fcs <= n_fcs;
                r_in2 <= n_in2;
                r_vf  <= n_vf;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_head.tag.last_of_test) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.tag.last_of_test) begin
            r_out_pi <= n_vf;
        end
    end

    assign o_valid                 = r_out_valid;
    assign o_possible_intersection = r_out_pi;

endmodule

// ===== rtl/plane_split_curve_hull_test_top.sv =====
// ----------------------------------------------------------------------------
// plane_split_curve_hull_test_top
// Plane separation test for the control polygons of two curves.
// ----------------------------------------------------------------------------
// Usage: configure the plane point, plane normal, tolerance and side sign
// through the configuration channel (always ready, one write per cycle)
// while the block is idle. Then stream the control points of the first
// curve followed by those of the second, one word per cycle, on the input
// channel; a word is taken when i_in_valid is high and o_in_stall is low.
// The word marked last_of_test yields one result word on the output
// channel, taken when o_out_valid is high and i_out_stall is low.
// Throughput is one point per cycle while o_in_stall is low. After its
// last point is taken, a result passes through the difference register,
// the product stage, the sum stage, the queue and the output register.
// When the receiver stalls, the result is held. Points keep flowing until
// the final point of the next test reaches the head of the queue; the
// four-entry queue then fills behind it and o_in_stall rises until the
// result is taken.
// Reset clears the pipeline, the queue and the test state, and loads the
// register defaults (all zero, side sign +1).
// ----------------------------------------------------------------------------
module plane_split_curve_hull_test_top #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [COORD_WIDTH-1:0]          i_coef_x,
    input  logic [COORD_WIDTH-1:0]          i_coef_y,
    input  logic [COORD_WIDTH-1:0]          i_coef_z,
    input  logic                            i_which_curve,
    input  logic                            i_is_bezier_curve,
    input  logic                            i_is_end_coef,
    input  logic                            i_last_of_test,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_possible_intersection,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  psch_pkg::t_cfg_idx              i_cfg_index,
    input  logic [psch_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import psch_pkg::*;

    logic [COORD_WIDTH-1:0] r_plane_x;
    logic [COORD_WIDTH-1:0] r_plane_y;
    logic [COORD_WIDTH-1:0] r_plane_z;
    logic [COORD_WIDTH-1:0] r_normal_x;
    logic [COORD_WIDTH-1:0] r_normal_y;
    logic [COORD_WIDTH-1:0] r_normal_z;
    logic [TOL_W-1:0]       r_tolerance;
    logic [SIDE_W-1:0]      r_side_sign;
    t_tag                   in_tag;
    logic                   q_full;
    logic                   q_nonempty;
    logic                   q_push;
    logic                   q_pop;
    t_qent                  q_wr_ent;
    t_qent                  q_head;

    assign o_cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane_x   <= '0;
            r_plane_y   <= '0;
            r_plane_z   <= '0;
            r_normal_x  <= '0;
            r_normal_y  <= '0;
            r_normal_z  <= '0;
            r_tolerance <= '0;
            r_side_sign <= SIDE_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_PLANE_X:   r_plane_x   <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_PLANE_Y:   r_plane_y   <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_PLANE_Z:   r_plane_z   <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_NORMAL_X:  r_normal_x  <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_NORMAL_Y:  r_normal_y  <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_NORMAL_Z:  r_normal_z  <= i_cfg_data[COORD_WIDTH-1:0];
                CFG_TOLERANCE: r_tolerance <= i_cfg_data[TOL_W-1:0];
                CFG_SIDE_SIGN: r_side_sign <= i_cfg_data[SIDE_W-1:0];
                default:       r_side_sign <= r_side_sign;
            endcase
        end
    end

    assign in_tag.which_curve     = i_which_curve;
    assign in_tag.is_bezier_curve = i_is_bezier_curve;
    assign in_tag.is_end_coef     = i_is_end_coef;
    assign in_tag.last_of_test    = i_last_of_test;

    // Distance pipeline and classification.
    psch_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_stall     (o_in_stall),
        .i_coef_x    (i_coef_x),
        .i_coef_y    (i_coef_y),
        .i_coef_z    (i_coef_z),
        .i_tag       (in_tag),
        .i_plane_x   (r_plane_x),
        .i_plane_y   (r_plane_y),
        .i_plane_z   (r_plane_z),
        .i_normal_x  (r_normal_x),
        .i_normal_y  (r_normal_y),
        .i_normal_z  (r_normal_z),
        .i_tolerance (r_tolerance),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_ent       (q_wr_ent)
    );

    // Queue between the two halves.
    psch_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_ent      (q_wr_ent),
        .i_pop      (q_pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (q_head)
    );

    // Sign sequence and verdict.
    psch_back u_back (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_nonempty              (q_nonempty),
        .i_head                  (q_head),
        .o_pop                   (q_pop),
        .i_side_sign             (r_side_sign),
        .o_valid                 (o_out_valid),
        .i_stall                 (i_out_stall),
        .o_possible_intersection (o_possible_intersection)
    );

endmodule

// ===== rtl/psch_checker.sv =====
// ----------------------------------------------------------------------------
// psch_checker
// Port-level checks on the plane separation test, bound to the top level.
// ----------------------------------------------------------------------------
module psch_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_possible_intersection
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_possible_intersection))
        else $error("result word changed while stalled");

    // Input back-pressure only arises from a stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> $past(o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word present after reset");

endmodule

bind plane_split_curve_hull_test_top psch_checker u_psch_checker (
    .i_clk                   (i_clk),
    .i_rst_n                 (i_rst_n),
    .o_in_stall              (o_in_stall),
    .o_out_valid             (o_out_valid),
    .i_out_stall             (i_out_stall),
    .o_possible_intersection (o_possible_intersection)
);
